>>> rtl/capsule_vertex_generator_defines.svh
// Assertion macros for the capsule vertex generator.
// Used by the top level; no other dependencies.
`ifndef CAPSULE_VERTEX_GENERATOR_DEFINES_SVH
`define CAPSULE_VERTEX_GENERATOR_DEFINES_SVH
`ifndef SYNTH
`define CVG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("capsule_vertex_generator: assertion failed");
`define CVG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("capsule_vertex_generator: assertion failed");
`else
`define CVG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CVG_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/cvg_pkg.sv
// Shared constants, tables and types of the capsule vertex generator.
// No dependencies.
`default_nettype none
package cvg_pkg;
  localparam int CORDIC_ITERATIONS = 16;
  localparam int CORDIC_STEPS = (CORDIC_ITERATIONS < 24) ? CORDIC_ITERATIONS : 24;
  localparam int DIV_STEPS = 32;
  localparam int DIV_QW = DIV_STEPS + 1;
  localparam int DIV_W = 10;
  localparam int CX_W = 33;
  localparam int CZ_W = 34;
  localparam int SC_W = 32;
  localparam int LATENCY = 41 + CORDIC_STEPS;

  localparam logic [3:0] CFG_RADIUS   = 4'd0;
  localparam logic [3:0] CFG_CYL_LEN  = 4'd1;
  localparam logic [3:0] CFG_RING_CNT = 4'd2;
  localparam logic [3:0] CFG_SEG_CNT  = 4'd3;

  localparam logic [15:0] RADIUS_RST   = 16'd256;
  localparam logic [15:0] CYL_LEN_RST  = 16'd512;
  localparam logic [7:0]  RING_CNT_RST = 8'd4;
  localparam logic [9:0]  SEG_CNT_RST  = 10'd16;

  localparam logic signed [CX_W-1:0] CORDIC_GAIN = 33'sd652032874;

  localparam logic [29:0] ATAN_TURNS [0:23] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10680862, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
  };

  typedef struct packed {
    logic        left;
    logic        oor;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
  } cvg_tag_t;
endpackage
`default_nettype wire

>>> rtl/cvg_div.sv
// Pipelined restoring divider, one quotient bit per stage: floor(num * 2^32 / den) for num < 2 * den.
// Depends on cvg_pkg.
`default_nettype none
module cvg_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [cvg_pkg::DIV_W-1:0] num,
  input  wire logic [cvg_pkg::DIV_W-1:0] den,
  input  wire cvg_pkg::cvg_tag_t         tag_i,
  output logic                           out_valid,
  output logic [cvg_pkg::DIV_QW-1:0]     quot,
  output cvg_pkg::cvg_tag_t              tag_o
);
  logic [cvg_pkg::DIV_STEPS:0]  v_r;
  logic [cvg_pkg::DIV_W-1:0]    rem_r [0:cvg_pkg::DIV_STEPS];
  logic [cvg_pkg::DIV_W-1:0]    den_r [0:cvg_pkg::DIV_STEPS];
  logic [cvg_pkg::DIV_QW-1:0]   quo_r [0:cvg_pkg::DIV_STEPS];
  cvg_pkg::cvg_tag_t            tag_r [0:cvg_pkg::DIV_STEPS];
  logic [cvg_pkg::DIV_W-1:0]    rem_nxt [0:cvg_pkg::DIV_STEPS];
  logic [cvg_pkg::DIV_QW-1:0]   quo_nxt [0:cvg_pkg::DIV_STEPS];
  logic [cvg_pkg::DIV_W:0]      sh   [1:cvg_pkg::DIV_STEPS];
  logic [cvg_pkg::DIV_W:0]      diff [1:cvg_pkg::DIV_STEPS];
  logic                         ge   [1:cvg_pkg::DIV_STEPS];
  logic                         ge0;
  logic [cvg_pkg::DIV_W-1:0]    diff0;

  always_comb begin
    ge0 = (num >= den);
    diff0 = num - den;
    rem_nxt[0] = ge0 ? diff0 : num;
    quo_nxt[0] = {{cvg_pkg::DIV_STEPS{1'b0}}, ge0};
    for (int k = 1; k <= cvg_pkg::DIV_STEPS; k++) begin
      sh[k] = {rem_r[k-1], 1'b0};
      diff[k] = sh[k] - {1'b0, den_r[k-1]};
      ge[k] = (sh[k] >= {1'b0, den_r[k-1]});
      rem_nxt[k] = ge[k] ? diff[k][cvg_pkg::DIV_W-1:0] : sh[k][cvg_pkg::DIV_W-1:0];
      quo_nxt[k] = {quo_r[k-1][cvg_pkg::DIV_QW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[cvg_pkg::DIV_STEPS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= rem_nxt[0];
    quo_r[0] <= quo_nxt[0];
    den_r[0] <= den;
    tag_r[0] <= tag_i;
    for (int k = 1; k <= cvg_pkg::DIV_STEPS; k++) begin
      rem_r[k] <= rem_nxt[k];
      quo_r[k] <= quo_nxt[k];
      den_r[k] <= den_r[k-1];
      tag_r[k] <= tag_r[k-1];
    end
  end

  assign out_valid = v_r[cvg_pkg::DIV_STEPS];
  assign quot      = quo_r[cvg_pkg::DIV_STEPS];
  assign tag_o     = tag_r[cvg_pkg::DIV_STEPS];
endmodule
`default_nettype wire

>>> rtl/cvg_cordic.sv
// Pipelined rotation-mode CORDIC: quadrant fold, one stage per step, negate and clamp.
// Depends on cvg_pkg.
`default_nettype none
module cvg_cordic (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic [31:0]                    angle,
  input  wire cvg_pkg::cvg_tag_t              tag_i,
  output logic                                out_valid,
  output logic signed [cvg_pkg::SC_W-1:0]     sin_o,
  output logic signed [cvg_pkg::SC_W-1:0]     cos_o,
  output cvg_pkg::cvg_tag_t                   tag_o
);
  localparam int N = cvg_pkg::CORDIC_STEPS;

  logic [N+1:0]                       v_r;
  logic signed [cvg_pkg::CX_W-1:0]    x_r [0:N];
  logic signed [cvg_pkg::CX_W-1:0]    y_r [0:N];
  logic signed [cvg_pkg::CZ_W-1:0]    z_r [0:N];
  logic                               flip_r [0:N];
  cvg_pkg::cvg_tag_t                  tag_r [0:N+1];
  logic signed [cvg_pkg::SC_W-1:0]    sin_r, cos_r;
  logic signed [cvg_pkg::CX_W-1:0]    x_nxt [1:N];
  logic signed [cvg_pkg::CX_W-1:0]    y_nxt [1:N];
  logic signed [cvg_pkg::CZ_W-1:0]    z_nxt [1:N];
  logic signed [cvg_pkg::CX_W-1:0]    dx, dy;
  logic signed [cvg_pkg::CZ_W-1:0]    at;
  logic signed [cvg_pkg::CZ_W-1:0]    za, z0_nxt;
  logic                               flip0_nxt;
  logic signed [cvg_pkg::CX_W-1:0]    xf, yf;
  logic signed [cvg_pkg::SC_W-1:0]    sin_nxt, cos_nxt;

  always_comb begin
    za = $signed({{2{angle[31]}}, angle});
    z0_nxt = za;
    flip0_nxt = 1'b0;
    if (za > 34'sd1073741824) begin
      z0_nxt = za - 34'sd2147483648;
      flip0_nxt = 1'b1;
    end else if (za < -34'sd1073741824) begin
      z0_nxt = za + 34'sd2147483648;
      flip0_nxt = 1'b1;
    end
  end

  always_comb begin
    dx = '0;
    dy = '0;
    at = '0;
    for (int k = 0; k < N; k++) begin
      dx = y_r[k] >>> k;
      dy = x_r[k] >>> k;
      at = $signed({{(cvg_pkg::CZ_W-30){1'b0}}, cvg_pkg::ATAN_TURNS[k]});
      if (!z_r[k][cvg_pkg::CZ_W-1]) begin
        x_nxt[k+1] = x_r[k] - dx;
        y_nxt[k+1] = y_r[k] + dy;
        z_nxt[k+1] = z_r[k] - at;
      end else begin
        x_nxt[k+1] = x_r[k] + dx;
        y_nxt[k+1] = y_r[k] - dy;
        z_nxt[k+1] = z_r[k] + at;
      end
    end
  end

  always_comb begin
    xf = flip_r[N] ? -x_r[N] : x_r[N];
    yf = flip_r[N] ? -y_r[N] : y_r[N];
    if (xf > 33'sd1073741824) begin
      cos_nxt = 32'sd1073741824;
    end else if (xf < -33'sd1073741824) begin
      cos_nxt = -32'sd1073741824;
    end else begin
      cos_nxt = xf[cvg_pkg::SC_W-1:0];
    end
    if (yf > 33'sd1073741824) begin
      sin_nxt = 32'sd1073741824;
    end else if (yf < -33'sd1073741824) begin
      sin_nxt = -32'sd1073741824;
    end else begin
      sin_nxt = yf[cvg_pkg::SC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[N:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]    <= cvg_pkg::CORDIC_GAIN;
    y_r[0]    <= '0;
    z_r[0]    <= z0_nxt;
    flip_r[0] <= flip0_nxt;
    tag_r[0]  <= tag_i;
    for (int k = 1; k <= N; k++) begin
      x_r[k]    <= x_nxt[k];
      y_r[k]    <= y_nxt[k];
      z_r[k]    <= z_nxt[k];
      flip_r[k] <= flip_r[k-1];
      tag_r[k]  <= tag_r[k-1];
    end
    tag_r[N+1] <= tag_r[N];
    sin_r <= sin_nxt;
    cos_r <= cos_nxt;
  end

  assign out_valid = v_r[N+1];
  assign sin_o     = sin_r;
  assign cos_o     = cos_r;
  assign tag_o     = tag_r[N+1];
endmodule
`default_nettype wire

>>> rtl/cvg_post.sv
// Four-stage back end: products, rounding, radial products, output register.
// Depends on cvg_pkg.
`default_nettype none
module cvg_post (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic signed [cvg_pkg::SC_W-1:0] psn,
  input  wire logic signed [cvg_pkg::SC_W-1:0] pcs,
  input  wire logic signed [cvg_pkg::SC_W-1:0] rsn,
  input  wire logic signed [cvg_pkg::SC_W-1:0] rcs,
  input  wire cvg_pkg::cvg_tag_t           tag_i,
  input  wire logic [15:0]                 radius,
  input  wire logic [15:0]                 cyl_len,
  output logic                             out_valid,
  output logic signed [17:0]               pos_x,
  output logic signed [17:0]               pos_y,
  output logic signed [17:0]               pos_z,
  output logic signed [15:0]               norm_x,
  output logic signed [15:0]               norm_y,
  output logic signed [15:0]               norm_z,
  output logic [16:0]                      tex_u,
  output logic [16:0]                      tex_v,
  output logic signed [15:0]               tan_y,
  output logic signed [15:0]               tan_z,
  output logic                             oor
);
  logic [3:0] v_r;

  // stage A
  logic signed [48:0] a_px_r, a_rp_r, a_px_nxt, a_rp_nxt;
  logic signed [63:0] a_ny_r, a_nz_r, a_ny_nxt, a_nz_nxt;
  logic [15:0]        a_nx_r, a_ty_r, a_tz_r;
  logic signed [cvg_pkg::SC_W-1:0] a_rsn_r, a_rcs_r;
  cvg_pkg::cvg_tag_t  a_tag_r;
  logic signed [31:0] nx_t, ty_t, tz_t;

  // stage B
  logic [17:0]        b_px_r;
  logic signed [32:0] b_rp_r;
  logic [15:0]        b_nx_r, b_ny_r, b_nz_r, b_ty_r, b_tz_r;
  logic signed [cvg_pkg::SC_W-1:0] b_rsn_r, b_rcs_r;
  cvg_pkg::cvg_tag_t  b_tag_r;
  logic signed [50:0] cen, px_sum;
  logic signed [48:0] rp_t;
  logic signed [63:0] ny_t, nz_t;

  // stage C
  logic signed [64:0] c_py_r, c_pz_r, c_py_nxt, c_pz_nxt;
  logic [17:0]        c_px_r;
  logic [15:0]        c_nx_r, c_ny_r, c_nz_r, c_ty_r, c_tz_r;
  cvg_pkg::cvg_tag_t  c_tag_r;

  // stage D
  logic signed [64:0] py_t, pz_t;
  logic signed [17:0] px_o_r, py_o_r, pz_o_r;
  logic signed [15:0] nx_o_r, ny_o_r, nz_o_r, ty_o_r, tz_o_r;
  logic [16:0]        tu_o_r, tv_o_r;
  logic               oor_o_r;

  always_comb begin
    a_px_nxt = psn * $signed({1'b0, radius});
    a_rp_nxt = pcs * $signed({1'b0, radius});
    a_ny_nxt = pcs * rsn;
    a_nz_nxt = pcs * rcs;
    nx_t = psn + 32'sd32768;
    ty_t = rcs + 32'sd32768;
    tz_t = rsn + 32'sd32768;
  end

  always_comb begin
    cen = $signed({6'd0, cyl_len, 29'd0});
    px_sum = (a_tag_r.left ? -cen : cen) + 51'(a_px_r) + (51'sd1 <<< 29);
    rp_t = a_rp_r + 49'sd32768;
    ny_t = a_ny_r + (64'sd1 <<< 45);
    nz_t = a_nz_r + (64'sd1 <<< 45);
  end

  always_comb begin
    c_py_nxt = b_rp_r * b_rsn_r;
    c_pz_nxt = b_rp_r * b_rcs_r;
    py_t = c_py_r + (65'sd1 <<< 43);
    pz_t = c_pz_r + (65'sd1 <<< 43);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    a_px_r  <= a_px_nxt;
    a_rp_r  <= a_rp_nxt;
    a_ny_r  <= a_ny_nxt;
    a_nz_r  <= a_nz_nxt;
    a_nx_r  <= nx_t[31:16];
    a_ty_r  <= ty_t[31:16];
    a_tz_r  <= 16'd0 - tz_t[31:16];
    a_rsn_r <= rsn;
    a_rcs_r <= rcs;
    a_tag_r <= tag_i;

    b_px_r  <= px_sum[47:30];
    b_rp_r  <= rp_t[48:16];
    b_ny_r  <= ny_t[61:46];
    b_nz_r  <= nz_t[61:46];
    b_nx_r  <= a_nx_r;
    b_ty_r  <= a_ty_r;
    b_tz_r  <= a_tz_r;
    b_rsn_r <= a_rsn_r;
    b_rcs_r <= a_rcs_r;
    b_tag_r <= a_tag_r;

    c_py_r  <= c_py_nxt;
    c_pz_r  <= c_pz_nxt;
    c_px_r  <= b_px_r;
    c_nx_r  <= b_nx_r;
    c_ny_r  <= b_ny_r;
    c_nz_r  <= b_nz_r;
    c_ty_r  <= b_ty_r;
    c_tz_r  <= b_tz_r;
    c_tag_r <= b_tag_r;

    if (c_tag_r.oor) begin
      px_o_r <= '0;
      py_o_r <= '0;
      pz_o_r <= '0;
      nx_o_r <= '0;
      ny_o_r <= '0;
      nz_o_r <= '0;
      tu_o_r <= '0;
      tv_o_r <= '0;
      ty_o_r <= '0;
      tz_o_r <= '0;
    end else begin
      px_o_r <= $signed(c_px_r);
      py_o_r <= py_t[61:44];
      pz_o_r <= pz_t[61:44];
      nx_o_r <= $signed(c_nx_r);
      ny_o_r <= $signed(c_ny_r);
      nz_o_r <= $signed(c_nz_r);
      tu_o_r <= c_tag_r.tex_u;
      tv_o_r <= c_tag_r.tex_v;
      ty_o_r <= $signed(c_ty_r);
      tz_o_r <= $signed(c_tz_r);
    end
    oor_o_r <= c_tag_r.oor;
  end

  assign out_valid = v_r[3];
  assign pos_x  = px_o_r;
  assign pos_y  = py_o_r;
  assign pos_z  = pz_o_r;
  assign norm_x = nx_o_r;
  assign norm_y = ny_o_r;
  assign norm_z = nz_o_r;
  assign tex_u  = tu_o_r;
  assign tex_v  = tv_o_r;
  assign tan_y  = ty_o_r;
  assign tan_z  = tz_o_r;
  assign oor    = oor_o_r;
endmodule
`default_nettype wire

>>> rtl/capsule_vertex_generator.sv
// Capsule vertex generator, fully pipelined: one grid point accepted per cycle.
// From the start transfer to the out_valid strobe a point passes through the input stage,
// the 33-stage divider, the angle stage, the 18-stage CORDIC and the 4-stage back end.
// Throughput: one vertex per cycle; busy is high only while reset is held and in the cycle after it.
// Reset (rst_n, synchronous, active low) empties the pipeline and loads register defaults.
`default_nettype none
`include "capsule_vertex_generator_defines.svh"
module capsule_vertex_generator (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [8:0]         in_profile_row,
  input  wire logic [9:0]         in_segment_column,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [3:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  output logic                    out_valid,
  output logic signed [17:0]      out_pos_x,
  output logic signed [17:0]      out_pos_y,
  output logic signed [17:0]      out_pos_z,
  output logic signed [15:0]      out_norm_x,
  output logic signed [15:0]      out_norm_y,
  output logic signed [15:0]      out_norm_z,
  output logic [16:0]             out_tex_u,
  output logic [16:0]             out_tex_v,
  output logic signed [15:0]      out_tan_y,
  output logic signed [15:0]      out_tan_z,
  output logic                    out_out_of_range
);
  logic        busy_r;
  logic [15:0] radius_r, cyl_len_r;
  logic [7:0]  ring_cnt_r;
  logic [9:0]  seg_cnt_r;

  logic [7:0]  ring_eff;
  logic [9:0]  seg_eff;
  logic [9:0]  rows;
  logic        accept, left_nxt, oor_nxt;
  logic [8:0]  h_nxt;

  logic        f_v_r, f_left_r, f_oor_r;
  logic [8:0]  f_h_r, f_row_r;
  logic [9:0]  f_col_r;
  cvg_pkg::cvg_tag_t f_tag;

  logic        da_v;
  logic [cvg_pkg::DIV_QW-1:0] qa, qb, qc;
  cvg_pkg::cvg_tag_t da_tag;

  logic [31:0] pang_nxt;
  logic [18:0] tu_t, tv_t;
  logic        p_v_r;
  logic [31:0] p_pang_r, p_rang_r;
  cvg_pkg::cvg_tag_t p_tag_r, p_tag_nxt;

  logic signed [cvg_pkg::SC_W-1:0] psn, pcs, rsn, rcs;
  logic        c_v;
  cvg_pkg::cvg_tag_t c_tag;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= cvg_pkg::RADIUS_RST;
      cyl_len_r  <= cvg_pkg::CYL_LEN_RST;
      ring_cnt_r <= cvg_pkg::RING_CNT_RST;
      seg_cnt_r  <= cvg_pkg::SEG_CNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cvg_pkg::CFG_RADIUS:   radius_r   <= cfg_data;
        cvg_pkg::CFG_CYL_LEN:  cyl_len_r  <= cfg_data;
        cvg_pkg::CFG_RING_CNT: ring_cnt_r <= cfg_data[7:0];
        cvg_pkg::CFG_SEG_CNT:  seg_cnt_r  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ring_eff = (ring_cnt_r == 8'd0) ? 8'd1 : ring_cnt_r;
    seg_eff  = (seg_cnt_r < 10'd3) ? 10'd3 : seg_cnt_r;
    rows     = {1'b0, ring_eff, 1'b0} + 10'd2;
    oor_nxt  = ({1'b0, in_profile_row} >= rows) || (in_segment_column > seg_eff);
    left_nxt = (in_profile_row <= {1'b0, ring_eff});
    h_nxt    = left_nxt ? in_profile_row : (in_profile_row - {1'b0, ring_eff} - 9'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
      p_v_r <= 1'b0;
    end else begin
      f_v_r <= accept;
      p_v_r <= da_v;
    end
  end

  always_ff @(posedge clk) begin
    f_left_r <= left_nxt;
    f_oor_r  <= oor_nxt;
    f_h_r    <= h_nxt;
    f_row_r  <= in_profile_row;
    f_col_r  <= in_segment_column;
  end

  always_comb begin
    f_tag = '0;
    f_tag.left = f_left_r;
    f_tag.oor  = f_oor_r;
  end

  cvg_div u_div_prof (
    .clk(clk), .rst_n(rst_n), .in_valid(f_v_r),
    .num({1'b0, f_h_r}), .den({2'b0, ring_eff}), .tag_i(f_tag),
    .out_valid(da_v), .quot(qa), .tag_o(da_tag)
  );

  cvg_div u_div_rad (
    .clk(clk), .rst_n(rst_n), .in_valid(f_v_r),
    .num(f_col_r), .den(seg_eff), .tag_i(f_tag),
    .out_valid(), .quot(qb), .tag_o()
  );

  cvg_div u_div_row (
    .clk(clk), .rst_n(rst_n), .in_valid(f_v_r),
    .num({1'b0, f_row_r}), .den({1'b0, ring_eff, 1'b1}), .tag_i(f_tag),
    .out_valid(), .quot(qc), .tag_o()
  );

  always_comb begin
    pang_nxt = {1'b0, qa[32:2]} - (da_tag.left ? 32'h4000_0000 : 32'h0);
    tu_t = {1'b0, qb[32:15]} + 19'd1;
    tv_t = {1'b0, qc[32:15]} + 19'd1;
    p_tag_nxt = da_tag;
    p_tag_nxt.tex_u = tu_t[17:1];
    p_tag_nxt.tex_v = tv_t[17:1];
  end

  always_ff @(posedge clk) begin
    p_pang_r <= pang_nxt;
    p_rang_r <= qb[31:0];
    p_tag_r  <= p_tag_nxt;
  end

  cvg_cordic u_cordic_prof (
    .clk(clk), .rst_n(rst_n), .in_valid(p_v_r), .angle(p_pang_r), .tag_i(p_tag_r),
    .out_valid(), .sin_o(psn), .cos_o(pcs), .tag_o()
  );

  cvg_cordic u_cordic_rad (
    .clk(clk), .rst_n(rst_n), .in_valid(p_v_r), .angle(p_rang_r), .tag_i(p_tag_r),
    .out_valid(c_v), .sin_o(rsn), .cos_o(rcs), .tag_o(c_tag)
  );

  cvg_post u_post (
    .clk(clk), .rst_n(rst_n), .in_valid(c_v),
    .psn(psn), .pcs(pcs), .rsn(rsn), .rcs(rcs), .tag_i(c_tag),
    .radius(radius_r), .cyl_len(cyl_len_r),
    .out_valid(out_valid),
    .pos_x(out_pos_x), .pos_y(out_pos_y), .pos_z(out_pos_z),
    .norm_x(out_norm_x), .norm_y(out_norm_y), .norm_z(out_norm_z),
    .tex_u(out_tex_u), .tex_v(out_tex_v),
    .tan_y(out_tan_y), .tan_z(out_tan_z), .oor(out_out_of_range)
  );

  `CVG_ASSERT_IMP(a_latency, clk, rst_n, 1'b1, out_valid == $past(start && !busy, cvg_pkg::LATENCY))
  `CVG_ASSERT_IMP(a_oor_zero, clk, rst_n, out_valid && out_out_of_range, out_pos_x == 18'sd0 && out_tex_u == 17'd0 && out_norm_y == 16'sd0)
  `CVG_ASSERT_IMP(a_tex_range, clk, rst_n, out_valid, out_tex_u <= 17'd65536 && out_tex_v <= 17'd65536)
endmodule
`default_nettype wire

>>> verif/capsule_vertex_generator_tb.sv
// Self-checking testbench for capsule_vertex_generator: directed and random grid points
// over several register settings, checked against a bit-accurate vertex predictor.
// Depends on rtl/cvg_pkg.sv and rtl/capsule_vertex_generator.sv.
`timescale 1ns / 100ps

typedef struct packed {
  logic [17:0] pos_x;
  logic [17:0] pos_y;
  logic [17:0] pos_z;
  logic [15:0] norm_x;
  logic [15:0] norm_y;
  logic [15:0] norm_z;
  logic [16:0] tex_u;
  logic [16:0] tex_v;
  logic [15:0] tan_y;
  logic [15:0] tan_z;
  logic        out_of_range;
} vertex_t;

class vertex_scoreboard;
  logic [15:0] radius = cvg_pkg::RADIUS_RST;
  logic [15:0] cyl_len = cvg_pkg::CYL_LEN_RST;
  logic [7:0]  ring_cnt = cvg_pkg::RING_CNT_RST;
  logic [9:0]  seg_cnt = cvg_pkg::SEG_CNT_RST;
  vertex_t     pending_vertices[$];
  int          mismatches = 0;

  function void set_reg(logic [3:0] idx, logic [15:0] data);
    case (idx)
      cvg_pkg::CFG_RADIUS:   radius = data;
      cvg_pkg::CFG_CYL_LEN:  cyl_len = data;
      cvg_pkg::CFG_RING_CNT: ring_cnt = data[7:0];
      cvg_pkg::CFG_SEG_CNT:  seg_cnt = data[9:0];
      default: ;
    endcase
  endfunction

  function void sincos(logic [31:0] ang, output longint sn, output longint cs);
    longint z, x, y, dx, dy;
    bit flip;
    z = ang[31] ? longint'(ang) - (longint'(1) << 32) : longint'(ang);
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > (longint'(1) << 30)) begin
      z -= longint'(1) << 31;
      flip = 1;
    end else if (z < -(longint'(1) << 30)) begin
      z += longint'(1) << 31;
      flip = 1;
    end
    for (int i = 0; i < cvg_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(cvg_pkg::ATAN_TURNS[i]);
      end else begin
        x += dx; y -= dy; z += longint'(cvg_pkg::ATAN_TURNS[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    if (y > (longint'(1) << 30)) y = longint'(1) << 30;
    if (y < -(longint'(1) << 30)) y = -(longint'(1) << 30);
    if (x > (longint'(1) << 30)) x = longint'(1) << 30;
    if (x < -(longint'(1) << 30)) x = -(longint'(1) << 30);
    sn = y;
    cs = x;
  endfunction

  function void note_point(logic [8:0] row, logic [9:0] col);
    vertex_t v;
    longint r_cnt, s_cnt, rows, h, psn, pcs, rsn, rcs, center, px, rp, t;
    logic [31:0] pang, rang;
    bit left;
    v = '0;
    r_cnt = (ring_cnt < 1) ? 1 : ring_cnt;
    s_cnt = (seg_cnt < 3) ? 3 : seg_cnt;
    rows = 2 * (r_cnt + 1);
    if (row >= rows || col > s_cnt) begin
      v.out_of_range = 1'b1;
    end else begin
      left = (row <= r_cnt);
      h = left ? row : row - r_cnt - 1;
      t = (h << 30) / r_cnt;
      pang = t[31:0];
      if (left) pang = pang - 32'h4000_0000;
      t = (longint'(col) << 32) / s_cnt;
      rang = t[31:0];
      sincos(pang, psn, pcs);
      sincos(rang, rsn, rcs);
      center = longint'(cyl_len) << 29;
      if (left) center = -center;
      px = (center + psn * longint'(radius) + (longint'(1) << 29)) >>> 30;
      rp = (pcs * longint'(radius) + (longint'(1) << 15)) >>> 16;
      v.pos_x = px[17:0];
      t = (rp * rsn + (longint'(1) << 43)) >>> 44; v.pos_y = t[17:0];
      t = (rp * rcs + (longint'(1) << 43)) >>> 44; v.pos_z = t[17:0];
      t = (psn + (longint'(1) << 15)) >>> 16; v.norm_x = t[15:0];
      t = (pcs * rsn + (longint'(1) << 45)) >>> 46; v.norm_y = t[15:0];
      t = (pcs * rcs + (longint'(1) << 45)) >>> 46; v.norm_z = t[15:0];
      t = ((longint'(col) << 17) + s_cnt) / (2 * s_cnt); v.tex_u = t[16:0];
      t = ((longint'(row) << 17) + rows - 1) / (2 * (rows - 1)); v.tex_v = t[16:0];
      t = (rcs + (longint'(1) << 15)) >>> 16; v.tan_y = t[15:0];
      t = -((rsn + (longint'(1) << 15)) >>> 16); v.tan_z = t[15:0];
    end
    pending_vertices = {pending_vertices, v};
  endfunction

  function void check_vertex(vertex_t got);
    vertex_t exp;
    if (pending_vertices.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected vertex %p", got);
      return;
    end
    exp = pending_vertices.pop_front();
    if (got.pos_x !== exp.pos_x || got.pos_y !== exp.pos_y || got.pos_z !== exp.pos_z ||
        got.norm_x !== exp.norm_x || got.norm_y !== exp.norm_y ||
        got.norm_z !== exp.norm_z || got.tex_u !== exp.tex_u || got.tex_v !== exp.tex_v ||
        got.tan_y !== exp.tan_y || got.tan_z !== exp.tan_z ||
        got.out_of_range !== exp.out_of_range) begin
      mismatches++;
      if (mismatches <= 10) $display("vertex mismatch\n  exp %p\n  got %p", exp, got);
    end
  endfunction
endclass

module capsule_vertex_generator_tb;
  localparam logic [3:0] CFG_UNUSED = 4'd9;
  localparam int STALL_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [8:0]  in_profile_row = '0;
  logic [9:0]  in_segment_column = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        out_valid;
  logic signed [17:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [15:0] out_norm_x, out_norm_y, out_norm_z, out_tan_y, out_tan_z;
  logic [16:0] out_tex_u, out_tex_v;
  logic        out_out_of_range;

  vertex_scoreboard sb = new();
  int idle_pct = 0;
  int quiet_cycles = 0;

  capsule_vertex_generator dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_point(in_profile_row, in_segment_column);
    if (rst_n && out_valid)
      sb.check_vertex('{out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y, out_norm_z,
                        out_tex_u, out_tex_v, out_tan_y, out_tan_z, out_out_of_range});
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("capsule_vertex_generator_tb: errors");
      $finish;
    end
  end

  task automatic write_reg(logic [3:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_point(int row, int col);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_profile_row <= 9'(row);
    in_segment_column <= 10'(col);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_vertices.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(logic [15:0] rad, logic [15:0] cyl, logic [7:0] rc,
                           logic [9:0] sc, int n, bit directed);
    int r_cnt, s_cnt;
    write_reg(cvg_pkg::CFG_RADIUS, rad);
    write_reg(cvg_pkg::CFG_CYL_LEN, cyl);
    write_reg(cvg_pkg::CFG_RING_CNT, {8'($urandom), rc});
    write_reg(cvg_pkg::CFG_SEG_CNT, {6'($urandom), sc});
    r_cnt = (rc < 1) ? 1 : rc;
    s_cnt = (sc < 3) ? 3 : sc;
    if (directed) begin
      send_point(0, 0);
      send_point(r_cnt, s_cnt / 4);
      send_point(r_cnt + 1, s_cnt / 2);
      send_point(2 * r_cnt + 1, s_cnt);
      send_point(2 * r_cnt + 2, 0);
      send_point(0, s_cnt + 1);
      send_point(511, 1023);
      send_point(r_cnt / 2, 3 * s_cnt / 4);
      send_point(r_cnt + 1 + r_cnt / 2, s_cnt - 1);
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) != 0)
        send_point($urandom_range(2 * r_cnt + 1), $urandom_range(s_cnt));
      else
        send_point($urandom_range(511), $urandom_range(1023));
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct = 21;
    run_phase(cvg_pkg::RADIUS_RST, cvg_pkg::CYL_LEN_RST, cvg_pkg::RING_CNT_RST,
              cvg_pkg::SEG_CNT_RST, 70, 1);
    run_phase(16'hFFFF, 16'hFFFF, 8'd255, 10'd1023, 80, 1);
    run_phase(16'd0, 16'd0, 8'd0, 10'd0, 70, 1);
    idle_pct = 51;
    run_phase(16'd256, 16'd0, 8'd1, 10'd3, 70, 1);
    run_phase(16'($urandom), 16'($urandom), 8'($urandom_range(1, 8)),
              10'($urandom_range(3, 64)), 80, 0);
    write_reg(CFG_UNUSED, 16'($urandom));
    run_phase(16'd12345, 16'd300, 8'd2, 10'd2, 70, 1);
    idle_pct = 0;
    run_phase(16'($urandom), 16'($urandom), 8'($urandom), 10'($urandom), 80, 0);
    run_phase(16'hFFFF, 16'd0, 8'd255, 10'd1, 80, 1);
    repeat (cvg_pkg::LATENCY + 10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_vertices.size() == 0)
      $display("capsule_vertex_generator_tb: clean");
    else
      $display("capsule_vertex_generator_tb: errors");
    $finish;
  end
endmodule

>>> capsule_vertex_generator.f
+incdir+rtl
rtl/cvg_pkg.sv
rtl/cvg_div.sv
rtl/cvg_cordic.sv
rtl/cvg_post.sv
rtl/capsule_vertex_generator.sv
verif/capsule_vertex_generator_tb.sv
